// File: rtl/tisa_pkg.sv
// Package for the typed integer ALU: word width, operation codes, type tags,
// error codes and the control struct carried down the pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tisa_pkg;
	localparam int WORD_BITS = 32;
	localparam int SHW       = $clog2(WORD_BITS);
	// stages: input reg, decode/multiply, WORD_BITS divide steps, output reg
	localparam int LATENCY   = WORD_BITS + 3;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
		OP_NEG = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_XOR = 5'd8, OP_BITNOT = 5'd9,
		OP_SHL = 5'd10, OP_SHR = 5'd11, OP_EQ = 5'd12, OP_NE = 5'd13, OP_LT = 5'd14,
		OP_GT = 5'd15, OP_LE = 5'd16, OP_GE = 5'd17, OP_NOT = 5'd18,
		OP_CASTINT = 5'd19, OP_CASTUINT = 5'd20, OP_CASTBOOL = 5'd21
	} op_t;

	localparam logic [1:0] T_INT  = 2'd0;
	localparam logic [1:0] T_UINT = 2'd1;
	localparam logic [1:0] T_BOOL = 2'd2;
	localparam logic [1:0] T_NONE = 2'd3;

	localparam logic [1:0] E_OK    = 2'd0;
	localparam logic [1:0] E_TYPE  = 2'd1;
	localparam logic [1:0] E_ZERO  = 2'd2;
	localparam logic [1:0] E_SHIFT = 2'd3;

	typedef struct packed {
		logic [1:0]           rtype;
		logic [1:0]           err;
		logic                 use_quo;
		logic                 use_rem;
		logic                 neg_res;
		logic [WORD_BITS-1:0] val;
	} ctl_t;
endpackage
`default_nettype wire

// File: rtl/typed_integer_stack_alu.sv
// Top level of the typed integer ALU: decode, multiply and a bit-per-stage divider.
// Depends on tisa_pkg.
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------------------
//  command  | start / busy      | kind, left_type, left_value, right_type, right_value
//  result   | done (one cycle)  | result_type, result_value, error_code
//
// From start to done every operation passes the input register, the decode register,
// the divider stages, one quotient bit per stage, and the output register. One
// command may enter every cycle. busy is high only while reset is asserted. The receiver
// cannot stall, so the pipeline never holds; reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module typed_integer_stack_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  kind,
	input  wire logic [1:0]  left_type,
	input  wire logic [31:0] left_value,
	input  wire logic [1:0]  right_type,
	input  wire logic [31:0] right_value,
	output logic             done,
	output logic [1:0]       result_type,
	output logic [31:0]      result_value,
	output logic [1:0]       error_code
);
	import tisa_pkg::*;
	localparam int W = WORD_BITS;

	// stage 0: input register
	logic         vld_s0;
	logic [4:0]   kind_s0;
	logic [1:0]   lt_s0, rt_s0;
	logic [W-1:0] a_s0, b_s0;

	assign busy = ~arst_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s0 <= 1'b0;
		else         vld_s0 <= start;
	end
	always_ff @(posedge clk) begin
		kind_s0 <= kind;
		lt_s0   <= left_type;
		rt_s0   <= right_type;
		a_s0    <= W'(left_value);
		b_s0    <= W'(right_value);
	end

	// stage 1 decode
	logic [W-1:0] a, b, ma, mb, sb, sh_r;
	logic         num2, sgn, na, nb, cmp_lt, cmp_eq, eqv, cnt_ok;
	logic [SHW-1:0] cnt;
	ctl_t         ctl;

	always_comb begin
		sb   = {1'b1, {(W-1){1'b0}}};
		a    = (lt_s0 == T_BOOL) ? (a_s0 & W'(1)) : a_s0;
		b    = (rt_s0 == T_BOOL) ? (b_s0 & W'(1)) : b_s0;
		num2 = (lt_s0 == rt_s0) && (lt_s0 == T_INT || lt_s0 == T_UINT);
		sgn  = (lt_s0 == T_INT);
		na   = sgn && a[W-1];
		nb   = sgn && b[W-1];
		ma   = na ? (W'(0) - a) : a;
		mb   = nb ? (W'(0) - b) : b;
		cmp_lt = sgn ? ((a ^ sb) < (b ^ sb)) : (a < b);
		cmp_eq = (a == b);
		eqv    = (lt_s0 == rt_s0) && (lt_s0 != T_NONE) && cmp_eq;
		cnt_ok = (b < W'(W));
		cnt    = b[SHW-1:0];
		sh_r   = sgn ? W'($signed(a) >>> cnt) : (a >> cnt);

		ctl         = '0;
		ctl.rtype   = lt_s0;
		ctl.err     = E_OK;
		unique case (kind_s0)
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR: begin
				if (!num2) ctl.err = E_TYPE;
				unique case (kind_s0)
					OP_ADD:  ctl.val = a + b;
					OP_SUB:  ctl.val = a - b;
					OP_MUL:  ctl.val = W'(a * b);
					OP_AND:  ctl.val = a & b;
					OP_OR:   ctl.val = a | b;
					default: ctl.val = a ^ b;
				endcase
			end
			OP_DIV, OP_MOD: begin
				if (!num2)          ctl.err = E_TYPE;
				else if (b == '0)   ctl.err = E_ZERO;
				ctl.use_quo = (kind_s0 == OP_DIV);
				ctl.use_rem = (kind_s0 == OP_MOD);
				ctl.neg_res = (kind_s0 == OP_DIV) ? (na != nb) : na;
			end
			OP_NEG: begin
				if (lt_s0 != T_INT) ctl.err = E_TYPE;
				ctl.val = W'(0) - a;
			end
			OP_BITNOT: begin
				if (lt_s0 != T_INT && lt_s0 != T_UINT) ctl.err = E_TYPE;
				ctl.val = ~a;
			end
			OP_SHL, OP_SHR: begin
				// count is checked before the left operand's tag
				priority if (rt_s0 != T_INT && rt_s0 != T_UINT) ctl.err = E_TYPE;
				else if (!cnt_ok)                            ctl.err = E_SHIFT;
				else if (lt_s0 != T_INT && lt_s0 != T_UINT)  ctl.err = E_TYPE;
				else                                         ctl.err = E_OK;
				ctl.val = (kind_s0 == OP_SHL) ? (a << cnt) : sh_r;
			end
			OP_EQ, OP_NE: begin
				ctl.rtype = T_BOOL;
				ctl.val   = W'((kind_s0 == OP_EQ) ? eqv : !eqv);
			end
			OP_LT, OP_GT, OP_LE, OP_GE: begin
				if (!num2) ctl.err = E_TYPE;
				ctl.rtype = T_BOOL;
				unique case (kind_s0)
					OP_LT:   ctl.val = W'(cmp_lt);
					OP_GT:   ctl.val = W'(!cmp_lt && !cmp_eq);
					OP_LE:   ctl.val = W'(cmp_lt || cmp_eq);
					default: ctl.val = W'(!cmp_lt);
				endcase
			end
			OP_NOT: begin
				if (lt_s0 != T_BOOL) ctl.err = E_TYPE;
				ctl.rtype = T_BOOL;
				ctl.val   = a ^ W'(1);
			end
			OP_CASTINT, OP_CASTUINT: begin
				if (lt_s0 == T_NONE) ctl.err = E_TYPE;
				ctl.rtype = (kind_s0 == OP_CASTINT) ? T_INT : T_UINT;
				ctl.val   = a;
			end
			OP_CASTBOOL: begin
				if (lt_s0 == T_NONE) ctl.err = E_TYPE;
				ctl.rtype = T_BOOL;
				ctl.val   = W'(a != '0);
			end
			default: ctl.err = E_TYPE;
		endcase
	end

	// divider pipeline: index 0 is the decode register, one quotient bit per step
	logic         vld_s2 [0:W];
	ctl_t         ctl_s2 [0:W];
	logic [W:0]   rem_s2 [0:W];
	logic [W-1:0] quo_s2 [0:W];
	logic [W-1:0] dsr_s2 [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2[0] <= 1'b0;
		else         vld_s2[0] <= vld_s0;
	end
	always_ff @(posedge clk) begin
		ctl_s2[0] <= ctl;
		rem_s2[0] <= '0;
		quo_s2[0] <= ma;
		dsr_s2[0] <= mb;
	end

	for (genvar i = 0; i < W; i++) begin : g_div
		logic [W:0] shf, dif;
		logic       qb;
		always_comb begin
			shf = {rem_s2[i][W-1:0], quo_s2[i][W-1]};
			dif = shf - {1'b0, dsr_s2[i]};
			qb  = ~dif[W];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s2[i+1] <= 1'b0;
			else         vld_s2[i+1] <= vld_s2[i];
		end
		always_ff @(posedge clk) begin
			ctl_s2[i+1] <= ctl_s2[i];
			rem_s2[i+1] <= qb ? dif : shf;
			quo_s2[i+1] <= {quo_s2[i][W-2:0], qb};
			dsr_s2[i+1] <= dsr_s2[i];
		end
	end

	// output stage
	ctl_t         fc;
	logic [W-1:0] mag, fin;
	always_comb begin
		fc  = ctl_s2[W];
		mag = fc.use_quo ? quo_s2[W] : rem_s2[W][W-1:0];
		if (fc.use_quo || fc.use_rem) fin = fc.neg_res ? (W'(0) - mag) : mag;
		else                          fin = fc.val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_s2[W];
	end
	always_ff @(posedge clk) begin
		error_code   <= fc.err;
		result_type  <= (fc.err == E_OK) ? fc.rtype : T_INT;
		result_value <= (fc.err == E_OK) ? 32'(fin) : 32'd0;
	end

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a command LATENCY cycles earlier");
	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error_code != E_OK) |-> (result_type == T_INT && result_value == 32'd0))
		else $error("error result carries nonzero type or value");
	a_bool_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_type == T_BOOL) |-> (result_value[31:1] == 31'd0))
		else $error("bool result wider than one bit");
endmodule
`default_nettype wire

// File: sim/tb_typed_integer_stack_alu.sv
// Testbench for typed_integer_stack_alu: directed and random commands, each result
// checked against an in-bench model of the typed operations. Depends on tisa_pkg.
`timescale 1ns / 1ps
module tb_typed_integer_stack_alu;
	import tisa_pkg::*;

	typedef struct packed {
		logic [4:0]  kind;
		logic [1:0]  ltype;
		logic [31:0] lval;
		logic [1:0]  rtype;
		logic [31:0] rval;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  rtype;
		logic [31:0] val;
		logic [1:0]  err;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [4:0] kind = '0;
	logic [1:0] left_type = '0;
	logic [31:0] left_value = '0;
	logic [1:0] right_type = '0;
	logic [31:0] right_value = '0;
	logic done;
	logic [1:0] result_type;
	logic [31:0] result_value;
	logic [1:0] error_code;

	cmd_t pending_cmds[$];
	res_t expected_results[$];
	int idle_pct = 36;
	bit fill_done = 0;
	int errors = 0;
	longint cycles = 0;

	typed_integer_stack_alu dut (.*);

	initial forever #5 clk = ~clk;

	function automatic res_t typed_op(cmd_t c);
		logic [31:0] a, b, r, ma, mb;
		logic num2, sgn, na, nb, eqv;
		res_t e;
		a = c.lval;
		b = c.rval;
		if (c.ltype == T_BOOL) a = {31'd0, a[0]};
		if (c.rtype == T_BOOL) b = {31'd0, b[0]};
		num2 = (c.ltype == c.rtype) && (c.ltype == T_INT || c.ltype == T_UINT);
		sgn = (c.ltype == T_INT);
		e = '{T_INT, 32'd0, E_TYPE};
		case (c.kind)
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR: if (num2) begin
				case (c.kind)
					OP_ADD: r = a + b;
					OP_SUB: r = a - b;
					OP_MUL: r = a * b;
					OP_AND: r = a & b;
					OP_OR: r = a | b;
					default: r = a ^ b;
				endcase
				e = '{c.ltype, r, E_OK};
			end
			OP_DIV, OP_MOD: if (num2) begin
				if (b == 0) e.err = E_ZERO;
				else if (!sgn) e = '{c.ltype, (c.kind == OP_DIV) ? a / b : a % b, E_OK};
				else begin
					na = a[31];
					nb = b[31];
					ma = na ? -a : a;
					mb = nb ? -b : b;
					if (c.kind == OP_DIV) begin
						r = ma / mb;
						if (na != nb) r = -r;
					end else begin
						r = ma % mb;
						if (na) r = -r;
					end
					e = '{c.ltype, r, E_OK};
				end
			end
			OP_NEG: if (c.ltype == T_INT) e = '{T_INT, -a, E_OK};
			OP_BITNOT: if (c.ltype == T_INT || c.ltype == T_UINT) e = '{c.ltype, ~a, E_OK};
			OP_SHL, OP_SHR: if (c.rtype == T_INT || c.rtype == T_UINT) begin
				// count is checked before the left tag
				if (b >= 32) e.err = E_SHIFT;
				else if (c.ltype == T_INT || c.ltype == T_UINT) begin
					if (c.kind == OP_SHL) r = a << b[4:0];
					else if (sgn) r = $signed(a) >>> b[4:0];
					else r = a >> b[4:0];
					e = '{c.ltype, r, E_OK};
				end
			end
			OP_EQ, OP_NE: begin
				eqv = (c.ltype == c.rtype) && (c.ltype != T_NONE) && (a == b);
				e = '{T_BOOL, {31'd0, (c.kind == OP_EQ) ? eqv : !eqv}, E_OK};
			end
			OP_LT, OP_GT, OP_LE, OP_GE: if (num2) begin
				if (sgn) begin
					a[31] = ~a[31];
					b[31] = ~b[31];
				end
				case (c.kind)
					OP_LT: eqv = a < b;
					OP_GT: eqv = a > b;
					OP_LE: eqv = a <= b;
					default: eqv = a >= b;
				endcase
				e = '{T_BOOL, {31'd0, eqv}, E_OK};
			end
			OP_NOT: if (c.ltype == T_BOOL) e = '{T_BOOL, {31'd0, ~a[0]}, E_OK};
			OP_CASTINT, OP_CASTUINT: if (c.ltype != T_NONE)
				e = '{(c.kind == OP_CASTINT) ? T_INT : T_UINT, a, E_OK};
			OP_CASTBOOL: if (c.ltype != T_NONE) e = '{T_BOOL, {31'd0, a != 0}, E_OK};
			default: ;
		endcase
		return e;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom_range(0, 40);
			4: return -$urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.kind = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(22, 31))
			: 5'($urandom_range(0, 21));
		c.ltype = ($urandom_range(0, 11) == 0) ? T_NONE : 2'($urandom_range(0, 2));
		// mostly matched tags so the arithmetic paths get exercised
		c.rtype = ($urandom_range(0, 3) != 0) ? c.ltype : 2'($urandom_range(0, 3));
		c.lval = rand_word();
		c.rval = rand_word();
		if ((c.kind == OP_SHL || c.kind == OP_SHR) && $urandom_range(0, 3) != 0)
			c.rval = $urandom_range(0, 31);
		return c;
	endfunction

	task automatic add_cmd(logic [4:0] k, logic [1:0] lt, logic [31:0] lv,
			logic [1:0] rt, logic [31:0] rv);
		pending_cmds.insert(pending_cmds.size(), cmd_t'{k, lt, lv, rt, rv});
	endtask

	initial begin
		for (int k = 0; k < 22; k++)
			add_cmd(5'(k), T_INT, 32'h8000_0000, T_INT, 32'hFFFF_FFFF);
		add_cmd(OP_DIV, T_UINT, 32'hFFFF_FFFF, T_UINT, 32'd0);
		add_cmd(OP_SHR, T_BOOL, 32'd1, T_INT, 32'd32);
		add_cmd(OP_EQ, T_NONE, 32'd5, T_NONE, 32'd5);
		add_cmd(5'd31, T_UINT, 32'd1, T_UINT, 32'd1);
		for (int i = 0; i < 1600; i++) pending_cmds.insert(pending_cmds.size(), rand_cmd());
		fill_done = 1;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && start && !busy) begin
			expected_results.insert(expected_results.size(),
				typed_op({kind, left_type, left_value, right_type, right_value}));
		end
		if (arst_n && pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
			cmd_t c;
			c = pending_cmds.pop_front();
			start <= 1'b1;
			kind <= c.kind;
			left_type <= c.ltype;
			left_value <= c.lval;
			right_type <= c.rtype;
			right_value <= c.rval;
		end else if (!(start && busy)) begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected transaction type=%0d value=%h err=%0d",
					$time, result_type, result_value, error_code);
				errors <= errors + 1;
			end else begin
				res_t e;
				e = expected_results.pop_front();
				if (e.rtype !== result_type || e.val !== result_value
						|| e.err !== error_code) begin
					$display("%0t: mismatch expected type=%0d value=%h err=%0d, got type=%0d value=%h err=%0d",
						$time, e.rtype, e.val, e.err, result_type, result_value, error_code);
					errors <= errors + 1;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (fill_done);
		wait (pending_cmds.size() < 1100);
		idle_pct = 70;
		wait (pending_cmds.size() < 550);
		idle_pct = 0;
		wait (pending_cmds.size() == 0);
		@(negedge clk);
		@(negedge clk);
		wait (expected_results.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		wait (cycles > 200000);
		$display("Some tests failed");
		$finish;
	end
endmodule

// File: files.f
rtl/tisa_pkg.sv
rtl/typed_integer_stack_alu.sv
sim/tb_typed_integer_stack_alu.sv
